// ===== rtl/nhb_pkg.sv =====
// shared types and constants for the network header builder
`timescale 1ns / 1ps
package nhb_pkg;

  localparam int BYTE_W    = 8;
  localparam int NET_W     = 16;
  localparam int LEN_W     = 4;
  localparam int ADDR_IN_W = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam int QDEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NETMSG  = 1'd1;

  localparam logic [BYTE_W-1:0] CTRL_NETMSG = 8'h80;
  localparam logic [BYTE_W-1:0] CTRL_DEST   = 8'h20;
  localparam logic [BYTE_W-1:0] CTRL_SRC    = 8'h08;
  localparam logic [BYTE_W-1:0] CTRL_REPLY  = 8'h04;
  localparam logic [NET_W-1:0]  BAD_NET     = 16'hFFFF;
  localparam logic [BYTE_W-1:0] VERSION_RST = 8'h01;

  typedef struct packed {
    logic              err;
    logic              dest;
    logic              src;
    logic [BYTE_W-1:0] version;
    logic [BYTE_W-1:0] ctrl;
    logic [NET_W-1:0]  dnet;
    logic [LEN_W-1:0]  dlen;
    logic [BYTE_W-1:0] hop;
    logic [NET_W-1:0]  snet;
    logic [LEN_W-1:0]  slen;
  } nhb_desc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_VER,
    ST_CTRL,
    ST_DNH,
    ST_DNL,
    ST_DLEN,
    ST_DADR,
    ST_SNH,
    ST_SNL,
    ST_SLEN,
    ST_SADR,
    ST_HOP
  } nhb_state_t;

endpackage

// ===== rtl/nhb_front.sv =====
// front end: configuration registers and request classification
`timescale 1ns / 1ps
module nhb_front #(
  parameter int MAX_ADDR_LEN = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nhb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nhb_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_dest_present,
  input  logic                            in_src_present,
  input  logic                            in_expecting_reply,
  input  logic [1:0]                      in_priority_req,
  input  logic [nhb_pkg::NET_W-1:0]       in_dest_network,
  input  logic [nhb_pkg::LEN_W-1:0]       in_dest_len,
  input  logic [nhb_pkg::ADDR_IN_W-1:0]   in_dest_address,
  input  logic [nhb_pkg::BYTE_W-1:0]      in_hop_count,
  input  logic [nhb_pkg::NET_W-1:0]       in_src_network,
  input  logic [nhb_pkg::LEN_W-1:0]       in_src_len,
  input  logic [nhb_pkg::ADDR_IN_W-1:0]   in_src_address,
  input  logic                            q_full,
  output logic                            q_push,
  output nhb_pkg::nhb_desc_t              q_desc,
  output logic [MAX_ADDR_LEN*8-1:0]       q_daddr,
  output logic [MAX_ADDR_LEN*8-1:0]       q_saddr
);
  import nhb_pkg::*;

  localparam int AW = MAX_ADDR_LEN * 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ADDR_LEN);

  logic [BYTE_W-1:0] version_r;
  logic              netmsg_r;
  logic [BYTE_W-1:0] ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RST;
      netmsg_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERSION: version_r <= cfg_data;
        CFG_NETMSG:  netmsg_r  <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    ctrl = {6'b0, in_priority_req};
    if (netmsg_r)           ctrl = ctrl | CTRL_NETMSG;
    if (in_dest_present)    ctrl = ctrl | CTRL_DEST;
    if (in_src_present)     ctrl = ctrl | CTRL_SRC;
    if (in_expecting_reply) ctrl = ctrl | CTRL_REPLY;
  end

  always_comb begin
    q_desc.err     = in_src_present && (in_src_network == BAD_NET);
    q_desc.dest    = in_dest_present;
    q_desc.src     = in_src_present;
    q_desc.version = version_r;
    q_desc.ctrl    = ctrl;
    q_desc.dnet    = in_dest_network;
    q_desc.dlen    = (in_dest_len > MAX_LEN) ? MAX_LEN : in_dest_len;
    q_desc.hop     = in_hop_count;
    q_desc.snet    = in_src_network;
    q_desc.slen    = (in_src_len > MAX_LEN) ? MAX_LEN : in_src_len;
  end

  assign q_daddr = in_dest_address[AW-1:0];
  assign q_saddr = in_src_address[AW-1:0];
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

// ===== rtl/nhb_queue.sv =====
// short request queue between front end and byte sequencer
`timescale 1ns / 1ps
module nhb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  import nhb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QDEPTH);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    if (do_pop)  rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

// ===== rtl/nhb_back.sv =====
// back end: header byte sequencer with output register
`timescale 1ns / 1ps
module nhb_back #(
  parameter int MAX_ADDR_LEN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  nhb_pkg::nhb_desc_t            q_desc,
  input  logic [MAX_ADDR_LEN*8-1:0]     q_daddr,
  input  logic [MAX_ADDR_LEN*8-1:0]     q_saddr,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [nhb_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic                          out_bad_source_net
);
  import nhb_pkg::*;

  localparam int AW = MAX_ADDR_LEN * 8;
  localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

  nhb_state_t        state_r, state_nxt;
  nhb_desc_t         desc_r;
  logic [AW-1:0]     daddr_r, saddr_r;
  logic [LEN_W-1:0]  rem_r;
  logic              ovalid_r;
  logic [BYTE_W-1:0] obyte_r;
  logic              olast_r, obad_r;

  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last, emit_bad;
  logic              go, ld;
  nhb_state_t        after_dest, after_src;

  assign go    = (state_r != ST_IDLE) && (!ovalid_r || out_pop);
  assign ld    = q_valid && ((state_r == ST_IDLE) || (go && emit_last));
  assign q_pop = ld;

  assign after_dest = desc_r.src ? ST_SNH : ST_HOP;
  assign after_src  = desc_r.dest ? ST_HOP : ST_IDLE;

  // byte for the current step
  always_comb begin
    emit_byte = '0;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_ERR: begin
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end
      ST_VER:  emit_byte = desc_r.version;
      ST_CTRL: begin
        emit_byte = desc_r.ctrl;
        emit_last = !desc_r.dest && !desc_r.src;
      end
      ST_DNH:  emit_byte = desc_r.dnet[15:8];
      ST_DNL:  emit_byte = desc_r.dnet[7:0];
      ST_DLEN: emit_byte = {{(BYTE_W-LEN_W){1'b0}}, desc_r.dlen};
      ST_DADR: emit_byte = daddr_r[7:0];
      ST_SNH:  emit_byte = desc_r.snet[15:8];
      ST_SNL:  emit_byte = desc_r.snet[7:0];
      ST_SLEN: begin
        emit_byte = {{(BYTE_W-LEN_W){1'b0}}, desc_r.slen};
        emit_last = !desc_r.dest && (desc_r.slen == '0);
      end
      ST_SADR: begin
        emit_byte = saddr_r[7:0];
        emit_last = !desc_r.dest && (rem_r == ONE);
      end
      ST_HOP: begin
        emit_byte = desc_r.hop;
        emit_last = 1'b1;
      end
    endcase
  end

  // step sequencing
  always_comb begin
    state_nxt = state_r;
    if (ld) begin
      state_nxt = q_desc.err ? ST_ERR : ST_VER;
    end else if (go) begin
      unique case (state_r)
        ST_IDLE: state_nxt = ST_IDLE;
        ST_ERR:  state_nxt = ST_IDLE;
        ST_VER:  state_nxt = ST_CTRL;
        ST_CTRL: state_nxt = desc_r.dest ? ST_DNH : (desc_r.src ? ST_SNH : ST_IDLE);
        ST_DNH:  state_nxt = ST_DNL;
        ST_DNL:  state_nxt = ST_DLEN;
        ST_DLEN: state_nxt = (desc_r.dlen != '0) ? ST_DADR : after_dest;
        ST_DADR: state_nxt = (rem_r == ONE) ? after_dest : ST_DADR;
        ST_SNH:  state_nxt = ST_SNL;
        ST_SNL:  state_nxt = ST_SLEN;
        ST_SLEN: state_nxt = (desc_r.slen != '0) ? ST_SADR : after_src;
        ST_SADR: state_nxt = (rem_r == ONE) ? after_src : ST_SADR;
        ST_HOP:  state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) ovalid_r <= 1'b1;
      else if (out_pop) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      obyte_r <= emit_byte;
      olast_r <= emit_last;
      obad_r  <= emit_bad;
    end
    if (ld) begin
      desc_r  <= q_desc;
      daddr_r <= q_daddr;
      saddr_r <= q_saddr;
    end else if (go) begin
      unique case (state_r)
        ST_DLEN: rem_r <= desc_r.dlen;
        ST_SLEN: rem_r <= desc_r.slen;
        ST_DADR: begin
          rem_r   <= rem_r - ONE;
          daddr_r <= daddr_r >> 8;
        end
        ST_SADR: begin
          rem_r   <= rem_r - ONE;
          saddr_r <= saddr_r >> 8;
        end
        default: ;
      endcase
    end
  end

  assign out_empty          = !ovalid_r;
  assign out_byte           = obyte_r;
  assign out_last           = olast_r;
  assign out_bad_source_net = obad_r;

endmodule

// ===== rtl/network_header_builder_unit.sv =====
// top level of the network header builder
//
// Requests enter through a queue-style port: a request is taken at a clock
// edge with in_push high and in_full low. Header bytes leave through a
// queue-style port: the oldest byte sits on out_byte, out_last and
// out_bad_source_net while out_empty is low and is taken when out_pop is
// high. One request gives version, control, optional destination and source
// blocks and, with a destination, hop count: 2 to 25 bytes, the last flagged
// by out_last. A request with a present source network of 65535 gives one
// error byte. Throughput is one byte per cycle while out_pop is high, set by
// the byte sequencer; a queued next request is loaded without a gap. A
// two-entry request queue lets new requests in while a header is still
// going out; when out_pop stays low the sequencer holds and the queue fills.
// Reset clears the queue and output, version becomes 1 and the network
// message bit 0. Registers are written through cfg_we, cfg_index, cfg_data.
`timescale 1ns / 1ps
module network_header_builder_unit #(
  parameter int MAX_ADDR_LEN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nhb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nhb_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_dest_present,
  input  logic                          in_src_present,
  input  logic                          in_expecting_reply,
  input  logic [1:0]                    in_priority_req,
  input  logic [nhb_pkg::NET_W-1:0]     in_dest_network,
  input  logic [nhb_pkg::LEN_W-1:0]     in_dest_len,
  input  logic [nhb_pkg::ADDR_IN_W-1:0] in_dest_address,
  input  logic [nhb_pkg::BYTE_W-1:0]    in_hop_count,
  input  logic [nhb_pkg::NET_W-1:0]     in_src_network,
  input  logic [nhb_pkg::LEN_W-1:0]     in_src_len,
  input  logic [nhb_pkg::ADDR_IN_W-1:0] in_src_address,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [nhb_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic                          out_bad_source_net
);
  import nhb_pkg::*;

  localparam int AW = MAX_ADDR_LEN * 8;
  localparam int DW = $bits(nhb_desc_t);
  localparam int QW = DW + 2 * AW;

  logic          q_push, q_full, q_valid, q_pop;
  nhb_desc_t     f_desc, b_desc;
  logic [AW-1:0] f_daddr, f_saddr, b_daddr, b_saddr;
  logic [QW-1:0] q_wdata, q_rdata;

  nhb_front #(.MAX_ADDR_LEN(MAX_ADDR_LEN)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_dest_present    (in_dest_present),
    .in_src_present     (in_src_present),
    .in_expecting_reply (in_expecting_reply),
    .in_priority_req    (in_priority_req),
    .in_dest_network    (in_dest_network),
    .in_dest_len        (in_dest_len),
    .in_dest_address    (in_dest_address),
    .in_hop_count       (in_hop_count),
    .in_src_network     (in_src_network),
    .in_src_len         (in_src_len),
    .in_src_address     (in_src_address),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_desc             (f_desc),
    .q_daddr            (f_daddr),
    .q_saddr            (f_saddr)
  );

  assign q_wdata = {f_desc, f_daddr, f_saddr};
  assign {b_desc, b_daddr, b_saddr} = q_rdata;

  nhb_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  nhb_back #(.MAX_ADDR_LEN(MAX_ADDR_LEN)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_desc             (b_desc),
    .q_daddr            (b_daddr),
    .q_saddr            (b_saddr),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_bad_source_net (out_bad_source_net)
  );

endmodule
